// ===== rtl/iirdf1_pkg.sv =====
// ---------------------------------------------------------------------------
// iirdf1_pkg: shared types and constants for the direct form I IIR filter
// Fixed point formats, register map, sequencer states and MAC control.
// ---------------------------------------------------------------------------
`default_nettype none

package iirdf1_pkg;

   localparam int SAMPLE_W   = 16;           // Q1.15 samples
   localparam int COEF_W     = 16;           // Q2.14 coefficients
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = 36;           // seven products plus headroom
   localparam int FRAC_SHIFT = 14;           // Q3.29 -> Q1.15
   localparam int RND_W      = ACC_W - FRAC_SHIFT;
   localparam int TAP_W      = 2;            // taps 0..3
   localparam int ADDR_W     = 5;            // seven registers at 4*i
   localparam int DATA_W     = 32;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_SHIFT - 1));
   localparam logic signed [RND_W-1:0] SAT_MAX    = RND_W'(32767);
   localparam logic signed [RND_W-1:0] SAT_MIN    = -RND_W'(32768);
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

   localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd16384;   // 1.0

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_B3 = 3'd3,
      REG_A1 = 3'd4,
      REG_A2 = 3'd5,
      REG_A3 = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] b3;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [COEF_W-1:0] a3;
   } coef_set_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic issue;     // operands valid this cycle
      logic first;     // first product of a sample: replaces the sum
      logic sub;       // feedback tap: subtract
   } mac_ctrl_type;

   typedef struct packed {
      logic pending;   // a product is still waiting to be accumulated
   } mac_stat_type;

endpackage

`default_nettype wire

// ===== rtl/iir_direct_form_one_filter.sv =====
// ---------------------------------------------------------------------------
// iir_direct_form_one_filter: third-order IIR filter, direct form I
// Fixed point: Q1.15 samples, Q2.14 coefficients, rounded and saturated.
//
// Usage:
//   req_ channel carries one Q1.15 input word per handshake (valid/stall).
//   rsp_ channel returns one filtered word plus a saturation flag per input.
//   csr_ port (APB-style) holds b0..b3 at 0x00..0x0C, a1..a3 at 0x10..0x18.
//   Write coefficients only while no sample is in flight.
// Timing:
//   One shared MAC does 2*FILTER_ORDER+1 products, one per cycle, then a
//   drain step and a round/saturate step; rsp_valid is registered from
//   the round/saturate step. A new word is taken only once the sequencer
//   is back in idle.
//   req_stall is high while a sample is being worked on.
// Reset:
//   Coefficients return to b0 = 1.0, all others 0; histories clear to zero.
// Stall:
//   A result holds in the output register while rsp_stall is high; the next
//   sample is still taken and worked on, and waits in the final step until
//   the output register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_one_filter
   import iirdf1_pkg::*;
#(
   parameter int FILTER_ORDER = 3
)(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input words
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   // result words
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_sample_out,
   output logic                            rsp_saturated,
   // coefficient port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [ADDR_W-1:0]          csr_paddr,
   input  wire logic [DATA_W-1:0]          csr_pwdata,
   output logic      [DATA_W-1:0]          csr_prdata,
   output logic                            csr_pready
);

   localparam int NSTEP      = 2 * FILTER_ORDER + 1;
   localparam int STEP_W     = $clog2(NSTEP);
   localparam int HIST_IDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

   coef_set_type  coef;
   mac_ctrl_type  mac_ctrl;
   mac_stat_type  mac_stat;
   logic signed [ACC_W-1:0] acc;

   seq_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] xh_ff [FILTER_ORDER];
   logic signed [SAMPLE_W-1:0] yh_ff [FILTER_ORDER];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_sat_ff;

   logic                       req_accept;
   logic                       finish_fire;
   logic                       out_blocked;

   // step -> tap: step 0 is b0*x, odd steps b_k*x[k-1], even steps a_k*y[k-1]
   logic [TAP_W-1:0]           tap;
   logic                       feedback;
   logic [HIST_IDX_W-1:0]      hidx;
   logic signed [COEF_W-1:0]   op_coef;
   logic signed [SAMPLE_W-1:0] op_data;

   // round and saturate
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [RND_W-1:0]    rnd;
   logic signed [SAMPLE_W-1:0] y_new;
   logic                       y_sat;

   iirdf1_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   iirdf1_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (op_coef),
      .data  (op_data),
      .acc   (acc),
      .stat  (mac_stat)
   );

   assign req_accept  = req_valid & ~req_stall;
   assign out_blocked = rsp_valid_ff & rsp_stall;

   // --- operand select ----------------------------------------------------
   assign tap      = TAP_W'(({1'b0, step_ff} + (STEP_W+1)'(1)) >> 1);
   assign feedback = (step_ff != '0) & ~step_ff[0];
   assign hidx     = HIST_IDX_W'(tap - TAP_W'(1));

   always_comb begin
      unique case (tap)
         2'd0:    op_coef = feedback ? '0 : coef.b0;
         2'd1:    op_coef = feedback ? coef.a1 : coef.b1;
         2'd2:    op_coef = feedback ? coef.a2 : coef.b2;
         default: op_coef = feedback ? coef.a3 : coef.b3;
      endcase
      if (tap == '0) begin
         op_data = x_ff;
      end else begin
         op_data = feedback ? yh_ff[hidx] : xh_ff[hidx];
      end
   end

   // --- sequencer: next state ---------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ISSUE;
         ST_ISSUE:  if (step_ff == LAST_STEP) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (!out_blocked) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // --- sequencer: outputs ------------------------------------------------
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      mac_ctrl.issue = (state_ff == ST_ISSUE);
      mac_ctrl.first = (step_ff == '0);
      mac_ctrl.sub   = feedback;
      finish_fire    = (state_ff == ST_FINISH) & ~out_blocked;
      step_in        = (state_ff == ST_ISSUE) ? step_ff + STEP_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // --- round half up, then clip to 16 bits -------------------------------
   assign acc_rnd = acc + ROUND_HALF;
   assign rnd     = acc_rnd[ACC_W-1:FRAC_SHIFT];

   always_comb begin
      priority if (rnd > SAT_MAX) begin
         y_new = OUT_MAX;
         y_sat = 1'b1;
      end else if (rnd < SAT_MIN) begin
         y_new = OUT_MIN;
         y_sat = 1'b1;
      end else begin
         y_new = rnd[SAMPLE_W-1:0];
         y_sat = 1'b0;
      end
   end

   // --- sample and histories ----------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= req_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_ORDER; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (finish_fire) begin
         xh_ff[0] <= x_ff;
         yh_ff[0] <= y_new;
         for (int i = 1; i < FILTER_ORDER; i++) begin
            xh_ff[i] <= xh_ff[i-1];
            yh_ff[i] <= yh_ff[i-1];
         end
      end
   end

   // --- output register ---------------------------------------------------
   assign rsp_valid_in = finish_fire | out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_sample_ff <= y_new;
         rsp_sat_ff    <= y_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

`ifndef ASSERT_OFF
   // a new result only ever appears right after the round/saturate step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared without a finish step");

   // the sum must be complete before it is rounded
   a_no_pending_at_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !mac_stat.pending)
      else $error("product still pending at finish");

   // a clipped result sits on a rail
   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_sample_out == OUT_MAX || rsp_sample_out == OUT_MIN))
      else $error("saturated flag without rail value");

   // an accepted word starts the product sequence at b0
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_ISSUE && step_ff == '0))
      else $error("accept did not start the sequence");
`endif

endmodule

`default_nettype wire

// ===== rtl/iirdf1_csr.sv =====
// ---------------------------------------------------------------------------
// iirdf1_csr: coefficient register bank
// APB-style write/read of the seven Q2.14 coefficients.
// ---------------------------------------------------------------------------
`default_nettype none

module iirdf1_csr
   import iirdf1_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output coef_set_type           coef
);

   coef_set_type coef_ff, coef_in;
   logic [2:0]   idx;
   logic         wr_en;
   logic signed [COEF_W-1:0] wdata;
   logic signed [COEF_W-1:0] rdata;

   assign idx        = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wdata      = csr_pwdata[COEF_W-1:0];
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (idx)
            REG_B0:  coef_in.b0 = wdata;
            REG_B1:  coef_in.b1 = wdata;
            REG_B2:  coef_in.b2 = wdata;
            REG_B3:  coef_in.b3 = wdata;
            REG_A1:  coef_in.a1 = wdata;
            REG_A2:  coef_in.a2 = wdata;
            REG_A3:  coef_in.a3 = wdata;
            default: ;   // outside the map: dropped
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_B0:  rdata = coef_ff.b0;
         REG_B1:  rdata = coef_ff.b1;
         REG_B2:  rdata = coef_ff.b2;
         REG_B3:  rdata = coef_ff.b3;
         REG_A1:  rdata = coef_ff.a1;
         REG_A2:  rdata = coef_ff.a2;
         REG_A3:  rdata = coef_ff.a3;
         default: rdata = '0;
      endcase
      csr_prdata = {{(DATA_W-COEF_W){rdata[COEF_W-1]}}, rdata};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff    <= '0;
         coef_ff.b0 <= B0_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/iirdf1_mac.sv =====
// ---------------------------------------------------------------------------
// iirdf1_mac: shared multiply-accumulate unit
// 16x16 signed multiply into a product register, then add or subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module iirdf1_mac
   import iirdf1_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mac_ctrl_type               ctrl,
   input  wire logic signed [COEF_W-1:0]   coef,
   input  wire logic signed [SAMPLE_W-1:0] data,
   output logic signed [ACC_W-1:0]         acc,
   output mac_stat_type                    stat
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pvld_ff, first_ff, sub_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  base;

   assign prod_in  = coef * data;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign base     = first_ff ? '0 : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (pvld_ff) begin
         acc_in = sub_ff ? (base - prod_ext) : (base + prod_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= ctrl.issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      first_ff <= ctrl.first;
      sub_ff   <= ctrl.sub;
      acc_ff   <= acc_in;
   end

   assign acc          = acc_ff;
   assign stat.pending = pvld_ff;

endmodule

`default_nettype wire
